FILE: hw/rtl/ecu_pkg.sv
`timescale 1ns / 1ps

package ecu_pkg;

	// Cell state: 0..8, carried in four bits.
	localparam int STATE_W      = 4;
	// One key digit: the low three bits of a state that is not 8.
	localparam int DIGIT_W      = 3;
	localparam int RULE_ENTRIES = 32768;

	localparam logic [STATE_W-1:0] ST_QUIET = 4'd0;
	localparam logic [STATE_W-1:0] ST_ONE   = 4'd1;
	localparam logic [STATE_W-1:0] ST_MAX   = 4'd8;

	// A rule RAM word holds the stored state plus one; zero marks an entry never written.
	localparam logic [STATE_W-1:0] CODE_EMPTY = 4'd0;

	typedef enum logic {
		REQ_COMPUTE = 1'b0,
		REQ_WRITE   = 1'b1
	} req_t;

endpackage

FILE: hw/rtl/ecu_rule_ram.sv
`timescale 1ns / 1ps

module ecu_rule_ram #(
	parameter int DEPTH  = ecu_pkg::RULE_ENTRIES,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic                        clk,
	input  logic                        wr_en,
	input  logic [ADDR_W-1:0]           wr_addr,
	input  logic [ecu_pkg::STATE_W-1:0] wr_data,
	input  logic                        rd_en,
	input  logic [ADDR_W-1:0]           rd_addr,
	output logic [ecu_pkg::STATE_W-1:0] rd_data
);

	logic [ecu_pkg::STATE_W-1:0] mem [DEPTH];
	logic [ecu_pkg::STATE_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Read data holds when not enabled; the pipeline relies on that while stalled.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

FILE: hw/rtl/evoloop_cell_update.sv
`timescale 1ns / 1ps
// Compute words pass s1 (rule RAM read) and s2, the register driving next_state.
// Throughput: one word per cycle if in_stall is low, set by the RAM read port.
// Rule writes take effect at their accept edge and produce no output word.
// Reset: after arst_n releases, a clear pass walks all RULE_ENTRIES rows of the
// rule RAM; in_stall stays high until it is done.
module evoloop_cell_update #(
	parameter int RULE_ENTRIES = ecu_pkg::RULE_ENTRIES
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        req_type,
	input  logic [ecu_pkg::STATE_W-1:0] center_state,
	input  logic [ecu_pkg::STATE_W-1:0] top_state,
	input  logic [ecu_pkg::STATE_W-1:0] right_state,
	input  logic [ecu_pkg::STATE_W-1:0] bottom_state,
	input  logic [ecu_pkg::STATE_W-1:0] left_state,
	input  logic [ecu_pkg::STATE_W-1:0] rule_value,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [ecu_pkg::STATE_W-1:0] next_state
);

	localparam int ADDR_W = $clog2(RULE_ENTRIES);
	localparam int KEY_W  = 5 * ecu_pkg::DIGIT_W;
	localparam logic [ADDR_W-1:0] LAST_ROW = ADDR_W'(RULE_ENTRIES - 1);

	typedef logic [ecu_pkg::STATE_W-1:0] state_t;

	// Out-of-range states read as 8.
	function automatic state_t sat_state(input state_t v);
		state_t r;
		r = (v > ecu_pkg::ST_MAX) ? ecu_pkg::ST_MAX : v;
		return r;
	endfunction

	function automatic logic is_mid(input state_t v);
		logic r;
		r = (v >= 4'd2) && (v <= 4'd7);
		return r;
	endfunction

	// ---------------------------------------------------------------
	// Input decode (combinational, ahead of the accept edge)
	// ---------------------------------------------------------------
	state_t s_c, s_t, s_r, s_b, s_l, s_val;
	logic   c_is8, nb_is8, nb_mid, use_mem;
	state_t fixed_res;
	logic [KEY_W-1:0] key;

	always_comb begin
		s_c    = sat_state(center_state);
		s_t    = sat_state(top_state);
		s_r    = sat_state(right_state);
		s_b    = sat_state(bottom_state);
		s_l    = sat_state(left_state);
		s_val  = sat_state(rule_value);
		c_is8  = (s_c == ecu_pkg::ST_MAX);
		nb_is8 = (s_t == ecu_pkg::ST_MAX) || (s_r == ecu_pkg::ST_MAX)
		      || (s_b == ecu_pkg::ST_MAX) || (s_l == ecu_pkg::ST_MAX);
		nb_mid = is_mid(s_t) || is_mid(s_r) || is_mid(s_b) || is_mid(s_l);
		// No 8 in the neighborhood: answer comes from the rule RAM.
		use_mem = !c_is8 && !nb_is8;
		key = {s_c[ecu_pkg::DIGIT_W-1:0], s_t[ecu_pkg::DIGIT_W-1:0],
		       s_r[ecu_pkg::DIGIT_W-1:0], s_b[ecu_pkg::DIGIT_W-1:0],
		       s_l[ecu_pkg::DIGIT_W-1:0]};

		// Fixed rules for a center of 8 or around a dead (8) neighbor.
		if (c_is8) begin
			fixed_res = ecu_pkg::ST_QUIET;
		end else begin
			unique case (s_c)
				4'd0, 4'd1: fixed_res = nb_mid ? ecu_pkg::ST_MAX : s_c;
				4'd2, 4'd3, 4'd5: fixed_res = ecu_pkg::ST_QUIET;
				default: fixed_res = ecu_pkg::ST_ONE;
			endcase
		end
	end

	// ---------------------------------------------------------------
	// Handshake and pipeline control
	// s1: RAM read data plus the decoded item; s2: output register.
	// ---------------------------------------------------------------
	logic   clearing_q;
	logic [ADDR_W-1:0] clr_idx_q;
	logic   valid_s1, valid_s2;
	logic   use_mem_s1, czero_s1;
	state_t fixed_s1, res_s1, next_s2;
	logic   in_fire, is_compute, advance;
	state_t rd_code;

	assign advance    = !valid_s2 || !out_stall;
	assign in_stall   = clearing_q || (valid_s1 && !advance);
	assign in_fire    = in_valid && !in_stall;
	assign is_compute = (ecu_pkg::req_t'(req_type) == ecu_pkg::REQ_COMPUTE);

	// ---------------------------------------------------------------
	// Rule RAM: write port shared by the clear pass and rule writes
	// ---------------------------------------------------------------
	logic   ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	state_t ram_wdata;

	always_comb begin
		if (clearing_q) begin
			ram_we    = 1'b1;
			ram_waddr = clr_idx_q;
			ram_wdata = ecu_pkg::CODE_EMPTY;
		end else begin
			// A key holding an 8 is dropped.
			ram_we    = in_fire && !is_compute && use_mem;
			ram_waddr = key[ADDR_W-1:0];
			ram_wdata = s_val + 4'd1;
		end
	end

	ecu_rule_ram #(
		.DEPTH  (RULE_ENTRIES),
		.ADDR_W (ADDR_W)
	) u_rule_ram (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (ram_waddr),
		.wr_data (ram_wdata),
		.rd_en   (in_fire && is_compute),
		.rd_addr (key[ADDR_W-1:0]),
		.rd_data (rd_code)
	);

	// Clear pass after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_idx_q  <= '0;
		end else if (clearing_q) begin
			clr_idx_q <= clr_idx_q + ADDR_W'(1);
			if (clr_idx_q == LAST_ROW) begin
				clearing_q <= 1'b0;
			end
		end
	end

	// Empty entry: 0 for a quiet center, 8 otherwise.
	always_comb begin
		if (!use_mem_s1) begin
			res_s1 = fixed_s1;
		end else if (rd_code == ecu_pkg::CODE_EMPTY) begin
			res_s1 = czero_s1 ? ecu_pkg::ST_QUIET : ecu_pkg::ST_MAX;
		end else begin
			res_s1 = rd_code - 4'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_fire && is_compute) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && is_compute) begin
			use_mem_s1 <= use_mem;
			czero_s1   <= (s_c == ecu_pkg::ST_QUIET);
			fixed_s1   <= fixed_res;
		end
		if (advance && valid_s1) begin
			next_s2 <= res_s1;
		end
	end

	assign out_valid  = valid_s2;
	assign next_state = next_s2;

endmodule

FILE: sim/evoloop_cell_update_tb.sv
`timescale 1ns / 1ps

// Scoreboard: keeps its own copy of the rule RAM and a queue of the
// next_state values still owed by the block.
class NextStateBoard;
	logic [ecu_pkg::STATE_W-1:0] rule_val [ecu_pkg::RULE_ENTRIES];
	bit                          rule_set [ecu_pkg::RULE_ENTRIES];
	logic [ecu_pkg::STATE_W-1:0] owed_q [$];
	int errors;
	int computes;
	int writes;
	int dropped_writes;
	int checked;

	// States 9..15 behave as 8.
	function automatic logic [ecu_pkg::STATE_W-1:0] clip(logic [ecu_pkg::STATE_W-1:0] s);
		return (s > ecu_pkg::ST_MAX) ? ecu_pkg::ST_MAX : s;
	endfunction

	function void note_word(ecu_pkg::req_t req, logic [3:0] c, logic [3:0] t, logic [3:0] r,
		logic [3:0] b, logic [3:0] l, logic [3:0] v);
		logic [3:0]  m;
		logic [3:0]  nb [4];
		logic [3:0]  res;
		logic [14:0] key;
		bit          nb_max;
		bit          nb_mid;
		m = clip(c);
		nb[0] = clip(t);
		nb[1] = clip(r);
		nb[2] = clip(b);
		nb[3] = clip(l);
		nb_max = 1'b0;
		nb_mid = 1'b0;
		foreach (nb[i]) begin
			if (nb[i] == ecu_pkg::ST_MAX)
				nb_max = 1'b1;
			if (nb[i] >= 4'd2 && nb[i] <= 4'd7)
				nb_mid = 1'b1;
		end
		key = {m[2:0], nb[0][2:0], nb[1][2:0], nb[2][2:0], nb[3][2:0]};

		if (req == ecu_pkg::REQ_WRITE) begin
			if (m == ecu_pkg::ST_MAX || nb_max) begin
				dropped_writes++;
			end else begin
				rule_val[key] = clip(v);
				rule_set[key] = 1'b1;
				writes++;
			end
			return;
		end

		computes++;
		if (m == ecu_pkg::ST_MAX) begin
			res = ecu_pkg::ST_QUIET;
		end else if (nb_max) begin
			if (m == ecu_pkg::ST_QUIET || m == ecu_pkg::ST_ONE)
				res = nb_mid ? ecu_pkg::ST_MAX : m;
			else if (m == 4'd2 || m == 4'd3 || m == 4'd5)
				res = ecu_pkg::ST_QUIET;
			else
				res = ecu_pkg::ST_ONE;
		end else if (rule_set[key]) begin
			res = rule_val[key];
		end else begin
			res = (m == ecu_pkg::ST_QUIET) ? ecu_pkg::ST_QUIET : ecu_pkg::ST_MAX;
		end
		owed_q.push_back(res);
	endfunction

	function void check_word(logic [3:0] got);
		logic [3:0] want;
		if (owed_q.size() == 0) begin
			$error("next_state: expected none, actual %0d", got);
			errors++;
			return;
		end
		want = owed_q.pop_front();
		checked++;
		if (got !== want) begin
			$error("next_state: expected %0d, actual %0d", want, got);
			errors++;
		end
	endfunction
endclass

module evoloop_cell_update_tb;

	// Clear pass after reset walks every RAM row with in_stall high; the
	// watchdog has to sit well above that plus the longest random stall run.
	localparam int WATCHDOG_LIMIT = 4 * ecu_pkg::RULE_ENTRIES + 20000;
	localparam int POOL_DEPTH     = 24;

	logic                        clk;
	logic                        arst_n;
	logic                        in_valid;
	logic                        in_stall;
	logic                        req_type;
	logic [ecu_pkg::STATE_W-1:0] center_state;
	logic [ecu_pkg::STATE_W-1:0] top_state;
	logic [ecu_pkg::STATE_W-1:0] right_state;
	logic [ecu_pkg::STATE_W-1:0] bottom_state;
	logic [ecu_pkg::STATE_W-1:0] left_state;
	logic [ecu_pkg::STATE_W-1:0] rule_value;
	logic                        out_valid;
	logic                        out_stall;
	logic [ecu_pkg::STATE_W-1:0] next_state;

	NextStateBoard sb;
	int            send_idle_pct;
	int            recv_stall_pct;
	int            quiet_cycles;
	logic [14:0]   key_pool [$];

	evoloop_cell_update i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.req_type     (req_type),
		.center_state (center_state),
		.top_state    (top_state),
		.right_state  (right_state),
		.bottom_state (bottom_state),
		.left_state   (left_state),
		.rule_value   (rule_value),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.next_state   (next_state)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Receiver back-pressure, redrawn every falling edge.
	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	// Result monitor: every word taken off the output is checked in order.
	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0)
			sb.check_word(next_state);
	end

	// Watchdog: consecutive cycles with no word moving on either side.
	always @(posedge clk) begin
		if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("Verification failed");
				$finish;
			end
		end
	end

	// Present one word at a falling edge, with random gaps in front of it, and
	// hold it until taken. Returns at the falling edge after the accept edge
	// with in_valid still high, so back-to-back words never toggle valid.
	task automatic send_word(input ecu_pkg::req_t req, input logic [3:0] c,
		input logic [3:0] t, input logic [3:0] r, input logic [3:0] b,
		input logic [3:0] l, input logic [3:0] v);
		bit taken;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid     <= 1'b1;
		req_type     <= req;
		center_state <= c;
		top_state    <= t;
		right_state  <= r;
		bottom_state <= b;
		left_state   <= l;
		rule_value   <= v;
		do begin
			@(posedge clk);
			taken = (in_stall === 1'b0);
			@(negedge clk);
		end while (!taken);
		sb.note_word(req, c, t, r, b, l, v);
	endtask

	// Hold the input off until the block owes nothing.
	task automatic drain_results();
		in_valid <= 1'b0;
		while (sb.owed_q.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Random word. Returns 0 for a write the block will drop (key holds an 8),
	// so those do not count toward the item budget.
	task automatic send_random_word(output bit counted);
		int          pick;
		int          pos;
		logic [14:0] key;
		logic [3:0]  s [5];
		counted = 1'b1;
		pick = $urandom_range(99);
		key = 15'($urandom);
		foreach (s[i])
			s[i] = {1'b0, key[14 - 3*i -: 3]};
		if (pick < 33) begin
			// rule write to a random key, remembered for later lookups
			key_pool.push_back(key);
			if (key_pool.size() > POOL_DEPTH)
				void'(key_pool.pop_front());
			send_word(ecu_pkg::REQ_WRITE, s[0], s[1], s[2], s[3], s[4], 4'($urandom));
		end else if (pick < 73 && key_pool.size() != 0) begin
			// lookup of a key that was written recently
			key = key_pool[$urandom_range(key_pool.size() - 1)];
			foreach (s[i])
				s[i] = {1'b0, key[14 - 3*i -: 3]};
			send_word(ecu_pkg::REQ_COMPUTE, s[0], s[1], s[2], s[3], s[4], 4'($urandom));
		end else if (pick < 83) begin
			// one neighbor saturated: fixed-rule path
			pos = $urandom_range(1, 4);
			s[pos] = 4'($urandom_range(8, 15));
			send_word(ecu_pkg::REQ_COMPUTE, s[0], s[1], s[2], s[3], s[4], 4'($urandom));
		end else if (pick < 91) begin
			// anything at all, including out-of-range states
			send_word(ecu_pkg::REQ_COMPUTE, 4'($urandom), 4'($urandom), 4'($urandom),
				4'($urandom), 4'($urandom), 4'($urandom));
		end else begin
			// write whose key holds an 8, dropped by the block
			pos = $urandom_range(0, 4);
			s[pos] = 4'($urandom_range(8, 15));
			send_word(ecu_pkg::REQ_WRITE, s[0], s[1], s[2], s[3], s[4], 4'($urandom));
			counted = 1'b0;
		end
	endtask

	initial begin
		int  done;
		bit  counted;
		int  phase_items [3];
		int  idle_a [3];
		int  idle_b [3];

		sb = new;
		phase_items = '{340, 330, 330};
		idle_a      = '{27, 75, 0};
		idle_b      = '{75, 27, 0};
		send_idle_pct  = idle_a[0];
		recv_stall_pct = idle_b[0];
		quiet_cycles   = 0;
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		out_stall    = 1'b0;
		req_type     = ecu_pkg::REQ_COMPUTE;
		center_state = '0;
		top_state    = '0;
		right_state  = '0;
		bottom_state = '0;
		left_state   = '0;
		rule_value   = '0;

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part. Unwritten rows: center 0 gives 0, anything else 8.
		send_word(ecu_pkg::REQ_COMPUTE, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd15);
		send_word(ecu_pkg::REQ_COMPUTE, 4'd3, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0);
		// write then read back, including an out-of-range rule value
		send_word(ecu_pkg::REQ_WRITE,   4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd5);
		send_word(ecu_pkg::REQ_COMPUTE, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0);
		send_word(ecu_pkg::REQ_WRITE,   4'd7, 4'd7, 4'd7, 4'd7, 4'd7, 4'd15);
		send_word(ecu_pkg::REQ_COMPUTE, 4'd7, 4'd7, 4'd7, 4'd7, 4'd7, 4'd0);
		send_word(ecu_pkg::REQ_WRITE,   4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd0);
		send_word(ecu_pkg::REQ_COMPUTE, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd9);
		// dropped writes: key with 8 or a saturating digit; center-3 and center-0 rows read back
		send_word(ecu_pkg::REQ_WRITE,   4'd3, 4'd8, 4'd0, 4'd0, 4'd0, 4'd2);
		send_word(ecu_pkg::REQ_COMPUTE, 4'd3, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0);
		send_word(ecu_pkg::REQ_WRITE,   4'd15, 4'd0, 4'd0, 4'd0, 4'd0, 4'd4);
		send_word(ecu_pkg::REQ_COMPUTE, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0);
		// overwrite of a row
		send_word(ecu_pkg::REQ_WRITE,   4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd8);
		send_word(ecu_pkg::REQ_WRITE,   4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd3);
		send_word(ecu_pkg::REQ_COMPUTE, 4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd0);
		// center 8 dies, also when saturated from 15
		send_word(ecu_pkg::REQ_COMPUTE, 4'd8, 4'd1, 4'd2, 4'd3, 4'd4, 4'd0);
		send_word(ecu_pkg::REQ_COMPUTE, 4'd15, 4'd15, 4'd15, 4'd15, 4'd15, 4'd15);
		// neighbor 8, quiet or one center: keeps itself or goes to 8
		send_word(ecu_pkg::REQ_COMPUTE, 4'd0, 4'd8, 4'd0, 4'd1, 4'd0, 4'd0);
		send_word(ecu_pkg::REQ_COMPUTE, 4'd1, 4'd9, 4'd1, 4'd0, 4'd1, 4'd0);
		send_word(ecu_pkg::REQ_COMPUTE, 4'd0, 4'd0, 4'd0, 4'd2, 4'd8, 4'd0);
		send_word(ecu_pkg::REQ_COMPUTE, 4'd1, 4'd7, 4'd12, 4'd0, 4'd0, 4'd0);
		// neighbor 8, other centers
		send_word(ecu_pkg::REQ_COMPUTE, 4'd2, 4'd8, 4'd0, 4'd0, 4'd0, 4'd0);
		send_word(ecu_pkg::REQ_COMPUTE, 4'd3, 4'd0, 4'd8, 4'd0, 4'd0, 4'd0);
		send_word(ecu_pkg::REQ_COMPUTE, 4'd5, 4'd0, 4'd0, 4'd10, 4'd0, 4'd0);
		send_word(ecu_pkg::REQ_COMPUTE, 4'd4, 4'd0, 4'd0, 4'd0, 4'd8, 4'd0);
		send_word(ecu_pkg::REQ_COMPUTE, 4'd6, 4'd8, 4'd8, 4'd8, 4'd8, 4'd0);
		send_word(ecu_pkg::REQ_COMPUTE, 4'd7, 4'd3, 4'd14, 4'd6, 4'd5, 4'd0);

		// Random part in three idling phases; input held off between them
		// until every owed result is back.
		for (int ph = 0; ph < 3; ph++) begin
			send_idle_pct  = idle_a[ph];
			recv_stall_pct = idle_b[ph];
			done = 0;
			while (done < phase_items[ph]) begin
				send_random_word(counted);
				if (counted)
					done++;
			end
			drain_results();
		end

		// catch any stray output word before the summary
		repeat (8) @(posedge clk);

		$display("Covered %0d cell updates, %0d rule writes, %0d dropped writes.",
			sb.computes, sb.writes, sb.dropped_writes);
		$display("Checked %0d results across sender/receiver idling phases.", sb.checked);
		if (sb.owed_q.size() != 0) begin
			$error("next_state: %0d expected results never arrived", sb.owed_q.size());
			sb.errors++;
		end
		if (sb.errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

FILE: files.f
hw/rtl/ecu_pkg.sv
hw/rtl/ecu_rule_ram.sv
hw/rtl/evoloop_cell_update.sv
sim/evoloop_cell_update_tb.sv
